@@ rtl/dust_sensor_frame_averager_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Dust sensor frame averager assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DUST_SENSOR_FRAME_AVERAGER_UNIT_MACROS_SVH
`define DUST_SENSOR_FRAME_AVERAGER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsfa: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DSFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsfa: next-cycle check failed");

`endif

@@ rtl/dsfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Dust sensor frame averager package
// Operation codes, frame constants, shared types and sequencer states.
// ----------------------------------------------------------------------------
package dsfa_pkg;

  localparam int WIN_LEN = 10;
  localparam int VAL_W   = 20;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POLL = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [7:0] FRAME_HEAD = 8'hAA;
  localparam logic [7:0] FRAME_TAIL = 8'hAB;
  localparam logic [7:0] CMD_TENTHS = 8'hC0;
  localparam logic [7:0] CMD_WHOLE  = 8'hCF;
  localparam logic [3:0] UNIT_SCALE = 4'd10;

  typedef struct packed {
    logic             ok;
    logic             kind;
    logic [VAL_W-1:0] fine;
    logic [VAL_W-1:0] coarse;
  } frame_t;

  typedef struct packed {
    logic             frame_ok;
    logic             frame_kind;
    logic [VAL_W-1:0] fine_reading;
    logic [VAL_W-1:0] coarse_reading;
    logic             new_reading;
    logic             average_valid;
    logic [VAL_W-1:0] fine_average;
    logic [VAL_W-1:0] coarse_average;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_FINE,
    ST_DIV_COARSE,
    ST_WRITE
  } state_t;

endpackage

@@ rtl/dsfa_channel_if.sv @@
// ----------------------------------------------------------------------------
// Dust sensor frame averager channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dsfa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink (input valid, operation, rx_byte, output ready);
endinterface

interface dsfa_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic        frame_kind;
  logic [19:0] fine_reading;
  logic [19:0] coarse_reading;
  logic        new_reading;
  logic        average_valid;
  logic [19:0] fine_average;
  logic [19:0] coarse_average;

  modport source (output valid, frame_ok, frame_kind, fine_reading, coarse_reading,
                  new_reading, average_valid, fine_average, coarse_average,
                  input ready);
  modport sink (input valid, frame_ok, frame_kind, fine_reading, coarse_reading,
                new_reading, average_valid, fine_average, coarse_average,
                output ready);
endinterface

@@ rtl/dsfa_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Dust sensor frame parser
// Ten-byte sliding window with head, tail, command and checksum decode.
// ----------------------------------------------------------------------------
module dsfa_frame_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [7:0]          rx_byte,
  output dsfa_pkg::frame_t    frame
);

  logic [7:0] win_r   [dsfa_pkg::WIN_LEN];
  logic [7:0] win_nxt [dsfa_pkg::WIN_LEN];
  logic [7:0] csum;
  logic [15:0] lo_word;
  logic [15:0] hi_word;
  logic        whole;

  // Window as it will look once this byte is shifted in.
  always_comb begin
    for (int i = 0; i < dsfa_pkg::WIN_LEN - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[dsfa_pkg::WIN_LEN-1] = rx_byte;
  end

  always_comb begin
    csum = 8'd0;
    for (int i = 2; i <= 7; i++) begin
      csum = csum + win_nxt[i];
    end
    lo_word = {win_nxt[3], win_nxt[2]};
    hi_word = {win_nxt[5], win_nxt[4]};
    whole   = (win_nxt[1] == dsfa_pkg::CMD_WHOLE);

    frame.ok   = (win_nxt[0] == dsfa_pkg::FRAME_HEAD) &&
                 (win_nxt[9] == dsfa_pkg::FRAME_TAIL) &&
                 ((win_nxt[1] == dsfa_pkg::CMD_TENTHS) || whole) &&
                 (csum == win_nxt[8]);
    frame.kind = whole;
    if (whole) begin
      frame.fine   = 20'(hi_word) * 20'(dsfa_pkg::UNIT_SCALE);
      frame.coarse = 20'(lo_word) * 20'(dsfa_pkg::UNIT_SCALE);
    end else begin
      frame.fine   = 20'(lo_word);
      frame.coarse = 20'(hi_word);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dsfa_pkg::WIN_LEN; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (push) begin
      win_r <= win_nxt;
    end
  end

endmodule

@@ rtl/dsfa_divider.sv @@
// ----------------------------------------------------------------------------
// Dust sensor frame averager divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "dust_sensor_frame_averager_unit_macros.svh"

module dsfa_divider #(
  parameter int SUM_W = 36,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             borrow;

  assign trial  = {rem_r, quo_r[SUM_W-1]};
  assign diff   = {1'b0, trial} - {2'b00, den_r};
  assign borrow = diff[DEN_W+1];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Subtract when the trial remainder covers the divisor, else restore.
      rem_nxt = borrow ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], !borrow};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `DSFA_ASSERT_NOW(a_start_when_free, start, !busy_r)
  `DSFA_ASSERT_NOW(a_done_not_busy, done_r, !busy_r)
  `DSFA_ASSERT_NOW(a_busy_has_count, busy_r, cnt_r != '0)

endmodule

@@ rtl/dust_sensor_frame_averager_unit.sv @@
// ----------------------------------------------------------------------------
// Dust sensor frame averager
// Parses sensor frames from serial bytes, accumulates readings, reports means.
// ----------------------------------------------------------------------------
// The result of a push or a poll is loaded into the output register at the
// transfer. A read with a nonzero count runs the shared restoring divider
// twice, PM2.5 then PM10, one quotient bit per cycle. Its result is loaded
// in ST_WRITE once both divisions are done, later if the output register is
// still held, and no input is taken until then. A new input is taken while
// the previous result waits, as long as the output register is freed at the
// same edge.
`include "dust_sensor_frame_averager_unit_macros.svh"

module dust_sensor_frame_averager_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  dsfa_in_if.sink           in_ch,
  dsfa_out_if.source        out_ch
);

  localparam int SUM_W = COUNT_BITS + dsfa_pkg::VAL_W;
  localparam int VW    = dsfa_pkg::VAL_W;

  dsfa_pkg::state_t  state_r, state_nxt;
  dsfa_pkg::frame_t  frame;
  dsfa_pkg::result_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              flag_r, flag_nxt;
  logic [SUM_W-1:0]  fine_sum_r, fine_sum_nxt;
  logic [SUM_W-1:0]  coarse_sum_r, coarse_sum_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [VW-1:0]     fine_avg_r, fine_avg_nxt;
  logic [VW-1:0]     coarse_avg_r, coarse_avg_nxt;

  logic              out_free;
  logic              accept;
  logic              push;
  logic              read_go;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_dividend;
  logic [SUM_W-1:0]  div_quo;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == dsfa_pkg::ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && (in_ch.operation == dsfa_pkg::OP_PUSH);
  assign read_go     = accept && (in_ch.operation == dsfa_pkg::OP_READ) &&
                       (count_r != '0);

  dsfa_frame_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rx_byte (in_ch.rx_byte),
    .frame   (frame)
  );

  dsfa_divider #(
    .SUM_W (SUM_W),
    .DEN_W (COUNT_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsfa_pkg::ST_IDLE:       if (read_go) state_nxt = dsfa_pkg::ST_DIV_FINE;
      dsfa_pkg::ST_DIV_FINE:   if (div_done) state_nxt = dsfa_pkg::ST_DIV_COARSE;
      dsfa_pkg::ST_DIV_COARSE: if (div_done) state_nxt = dsfa_pkg::ST_WRITE;
      dsfa_pkg::ST_WRITE:      if (out_free) state_nxt = dsfa_pkg::ST_IDLE;
      default:                 state_nxt = dsfa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = coarse_sum_r;
    unique case (state_r)
      dsfa_pkg::ST_IDLE: begin
        div_start    = read_go;
        div_dividend = fine_sum_r;
      end
      dsfa_pkg::ST_DIV_FINE: begin
        div_start = div_done;
      end
      dsfa_pkg::ST_DIV_COARSE: ;
      dsfa_pkg::ST_WRITE: ;
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    flag_nxt       = flag_r;
    fine_sum_nxt   = fine_sum_r;
    coarse_sum_nxt = coarse_sum_r;
    count_nxt      = count_r;
    fine_avg_nxt   = fine_avg_r;
    coarse_avg_nxt = coarse_avg_r;

    if (accept && !read_go) begin
      res_nxt       = '0;
      out_valid_nxt = 1'b1;
      case (in_ch.operation)
        dsfa_pkg::OP_PUSH: begin
          if (frame.ok) begin
            res_nxt.frame_ok       = 1'b1;
            res_nxt.frame_kind     = frame.kind;
            res_nxt.fine_reading   = frame.fine;
            res_nxt.coarse_reading = frame.coarse;
            flag_nxt               = 1'b1;
            // Hold the sums once the count has saturated.
            if (count_r != {COUNT_BITS{1'b1}}) begin
              fine_sum_nxt   = fine_sum_r + SUM_W'(frame.fine);
              coarse_sum_nxt = coarse_sum_r + SUM_W'(frame.coarse);
              count_nxt      = count_r + 1'b1;
            end
          end
        end
        dsfa_pkg::OP_POLL: begin
          res_nxt.new_reading = flag_r;
          flag_nxt            = 1'b0;
        end
        default: ;
      endcase
    end

    if (div_done && (state_r == dsfa_pkg::ST_DIV_FINE)) begin
      fine_avg_nxt = div_quo[VW-1:0];
    end
    if (div_done && (state_r == dsfa_pkg::ST_DIV_COARSE)) begin
      coarse_avg_nxt = div_quo[VW-1:0];
    end

    if ((state_r == dsfa_pkg::ST_WRITE) && out_free) begin
      res_nxt                = '0;
      res_nxt.average_valid  = 1'b1;
      res_nxt.fine_average   = fine_avg_r;
      res_nxt.coarse_average = coarse_avg_r;
      out_valid_nxt          = 1'b1;
      fine_sum_nxt           = '0;
      coarse_sum_nxt         = '0;
      count_nxt              = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dsfa_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      flag_r       <= 1'b0;
      fine_sum_r   <= '0;
      coarse_sum_r <= '0;
      count_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      flag_r       <= flag_nxt;
      fine_sum_r   <= fine_sum_nxt;
      coarse_sum_r <= coarse_sum_nxt;
      count_r      <= count_nxt;
    end
    res_r        <= res_nxt;
    fine_avg_r   <= fine_avg_nxt;
    coarse_avg_r <= coarse_avg_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_ok       = res_r.frame_ok;
  assign out_ch.frame_kind     = res_r.frame_kind;
  assign out_ch.fine_reading   = res_r.fine_reading;
  assign out_ch.coarse_reading = res_r.coarse_reading;
  assign out_ch.new_reading    = res_r.new_reading;
  assign out_ch.average_valid  = res_r.average_valid;
  assign out_ch.fine_average   = res_r.fine_average;
  assign out_ch.coarse_average = res_r.coarse_average;

  `DSFA_ASSERT_NOW(a_empty_sums, count_r == '0, fine_sum_r == '0 && coarse_sum_r == '0)
  `DSFA_ASSERT_NEXT(a_frame_sets_flag, push && frame.ok, flag_r)
  `DSFA_ASSERT_NOW(a_done_in_div, div_done,
    state_r == dsfa_pkg::ST_DIV_FINE || state_r == dsfa_pkg::ST_DIV_COARSE)

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dust sensor frame averager testbench
// Checks frame parsing, the new-reading flag and averaging.
// A directed table runs first, then random frame traffic. The run ends with a
// read, a short chain of overlapping frames, a poll and two reads, no idling.
// Results are checked against an in-bench predictor or a directed row's want.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          CLK_PERIOD   = 8;
  localparam int          CNT_BITS     = 16;
  localparam int          VW           = dsfa_pkg::VAL_W;
  localparam int          SUM_W        = CNT_BITS + VW;
  localparam int          RANDOM_ITEMS = 330;
  localparam int          TAIL_FRAMES  = 6;
  localparam int          DRAIN_CYCLES = 200;
  // Reads dominate the run length, with the longest idles and stalls.
  localparam int          CYCLE_LIMIT  = 200_000;
  localparam int          MAX_REPORTS  = 60;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  localparam dsfa_pkg::result_t QUIET        = '0;
  localparam dsfa_pkg::result_t C0_FRAME_MAX = '{frame_ok: 1'b1,
                                                 fine_reading: 20'd65535,
                                                 default: '0};
  localparam dsfa_pkg::result_t CF_FRAME_MAX = '{frame_ok: 1'b1, frame_kind: 1'b1,
                                                 fine_reading: 20'd655350,
                                                 default: '0};
  localparam dsfa_pkg::result_t FLAG_RAISED  = '{new_reading: 1'b1, default: '0};

  typedef enum logic [2:0] {
    FAULT_NONE,
    FAULT_HEAD,
    FAULT_CMD,
    FAULT_SUM,
    FAULT_TAIL
  } frame_fault_t;

  typedef struct {
    logic [1:0]        op;
    logic [7:0]        rx;
    bit                typed;
    dsfa_pkg::result_t want;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dsfa_in_if  in_ch ();
  dsfa_out_if out_ch ();

  dust_sensor_frame_averager_unit #(
    .COUNT_BITS(CNT_BITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state, mirrors the block after reset.
  logic [7:0]          win_bytes [dsfa_pkg::WIN_LEN] = '{default: 8'h00};
  logic                fresh_flag    = 1'b0;
  logic [SUM_W-1:0]    fine_acc      = '0;
  logic [SUM_W-1:0]    coarse_acc    = '0;
  logic [CNT_BITS-1:0] reading_total = '0;

  dsfa_pkg::result_t awaited_reports [$];
  stim_row_t         directed_rows [26];
  bit                idle_on     = 1'b1;
  int                items_sent  = 0;
  int                fail_count  = 0;
  int                cycle_count = 0;

  function automatic dsfa_pkg::result_t parse_and_average(input logic [1:0] op,
                                                          input logic [7:0] rx);
    dsfa_pkg::result_t r;
    logic [7:0]        csum;
    logic [VW-1:0]     fine_val;
    logic [VW-1:0]     coarse_val;
    int                i;
    r = '0;
    case (op)
      dsfa_pkg::OP_PUSH: begin
        for (i = 0; i < dsfa_pkg::WIN_LEN - 1; i++) win_bytes[i] = win_bytes[i + 1];
        win_bytes[dsfa_pkg::WIN_LEN - 1] = rx;
        csum = '0;
        for (i = 2; i <= 7; i++) csum = csum + win_bytes[i];
        if (win_bytes[0] == dsfa_pkg::FRAME_HEAD && win_bytes[9] == dsfa_pkg::FRAME_TAIL &&
            (win_bytes[1] == dsfa_pkg::CMD_TENTHS || win_bytes[1] == dsfa_pkg::CMD_WHOLE) &&
            csum == win_bytes[8]) begin
          if (win_bytes[1] == dsfa_pkg::CMD_WHOLE) begin
            fine_val   = {4'h0, win_bytes[5], win_bytes[4]} * 20'(dsfa_pkg::UNIT_SCALE);
            coarse_val = {4'h0, win_bytes[3], win_bytes[2]} * 20'(dsfa_pkg::UNIT_SCALE);
          end else begin
            fine_val   = {4'h0, win_bytes[3], win_bytes[2]};
            coarse_val = {4'h0, win_bytes[5], win_bytes[4]};
          end
          fresh_flag = 1'b1;
          // Hold the sums once the count is pinned at its maximum.
          if (reading_total != {CNT_BITS{1'b1}}) begin
            fine_acc      = fine_acc + SUM_W'(fine_val);
            coarse_acc    = coarse_acc + SUM_W'(coarse_val);
            reading_total = reading_total + 1'b1;
          end
          r.frame_ok       = 1'b1;
          r.frame_kind     = (win_bytes[1] == dsfa_pkg::CMD_WHOLE);
          r.fine_reading   = fine_val;
          r.coarse_reading = coarse_val;
        end
      end
      dsfa_pkg::OP_POLL: begin
        r.new_reading = fresh_flag;
        fresh_flag    = 1'b0;
      end
      dsfa_pkg::OP_READ: begin
        if (reading_total != '0) begin
          r.average_valid  = 1'b1;
          r.fine_average   = VW'(fine_acc / SUM_W'(reading_total));
          r.coarse_average = VW'(coarse_acc / SUM_W'(reading_total));
          fine_acc         = '0;
          coarse_acc       = '0;
          reading_total    = '0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void log_mismatch(input string field, input longint unsigned want,
                                       input longint unsigned got);
    if (fail_count < MAX_REPORTS) begin
      $error("%s: expected %0d, got %0d", field, want, got);
    end
    fail_count++;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [1:0] op, input logic [7:0] rx, input bit typed,
                           input dsfa_pkg::result_t typed_want);
    dsfa_pkg::result_t predicted;
    int                gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap             = $urandom_range(1, 6);
      in_ch.valid     = 1'b0;
      in_ch.operation = 2'($urandom);
      in_ch.rx_byte   = 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.rx_byte   = rx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = parse_and_average(op, rx);
    awaited_reports.push_back(typed ? typed_want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_fault_t fault);
    logic [7:0] frame_bytes [dsfa_pkg::WIN_LEN];
    logic [7:0] csum;
    logic [1:0] side_op;
    int         i;
    frame_bytes[0] = dsfa_pkg::FRAME_HEAD;
    frame_bytes[1] = $urandom_range(0, 1) ? dsfa_pkg::CMD_WHOLE : dsfa_pkg::CMD_TENTHS;
    csum = '0;
    for (i = 2; i < 8; i++) begin
      case ($urandom_range(0, 7))
        0:       frame_bytes[i] = 8'h00;
        1:       frame_bytes[i] = 8'hFF;
        default: frame_bytes[i] = 8'($urandom);
      endcase
      csum = csum + frame_bytes[i];
    end
    frame_bytes[8] = csum;
    frame_bytes[9] = dsfa_pkg::FRAME_TAIL;
    case (fault)
      FAULT_HEAD: frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
      FAULT_CMD: begin
        do frame_bytes[1] = 8'($urandom);
        while (frame_bytes[1] == dsfa_pkg::CMD_TENTHS ||
               frame_bytes[1] == dsfa_pkg::CMD_WHOLE);
      end
      FAULT_SUM:  frame_bytes[8] = frame_bytes[8] ^ 8'($urandom_range(1, 255));
      FAULT_TAIL: frame_bytes[9] = frame_bytes[9] ^ 8'($urandom_range(1, 255));
      default: begin
      end
    endcase
    for (i = 0; i < dsfa_pkg::WIN_LEN; i++) begin
      // Polls, reads and unused codes leave the byte window alone, so slip some in mid-frame.
      if (i > 0 && $urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    side_op = dsfa_pkg::OP_POLL;
          2:       side_op = dsfa_pkg::OP_READ;
          default: side_op = OP_UNUSED;
        endcase
        send_item(side_op, 8'($urandom), 1'b0, QUIET);
      end
      send_item(dsfa_pkg::OP_PUSH, frame_bytes[i], 1'b0, QUIET);
    end
  endtask

  // Back-to-back frames five bytes apart: each block is head, command, two data
  // bytes, tail, so the tail of one frame sits where the next one needs it. The
  // second data byte of a block closes the checksum of the frame before it.
  task automatic send_frame_chain(input int frames);
    logic [7:0] cmd_byte;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
    logic [7:0] prev_lo;
    logic [7:0] prev_hi;
    int         k;
    prev_lo = '0;
    prev_hi = '0;
    for (k = 0; k <= frames; k++) begin
      cmd_byte = $urandom_range(0, 1) ? dsfa_pkg::CMD_WHOLE : dsfa_pkg::CMD_TENTHS;
      lo_byte  = 8'($urandom);
      if (k == 0) begin
        hi_byte = 8'($urandom);
      end else begin
        hi_byte = prev_lo + prev_hi + dsfa_pkg::FRAME_TAIL + dsfa_pkg::FRAME_HEAD +
                  cmd_byte + lo_byte;
      end
      send_item(dsfa_pkg::OP_PUSH, dsfa_pkg::FRAME_HEAD, 1'b0, QUIET);
      send_item(dsfa_pkg::OP_PUSH, cmd_byte, 1'b0, QUIET);
      send_item(dsfa_pkg::OP_PUSH, lo_byte, 1'b0, QUIET);
      send_item(dsfa_pkg::OP_PUSH, hi_byte, 1'b0, QUIET);
      send_item(dsfa_pkg::OP_PUSH, dsfa_pkg::FRAME_TAIL, 1'b0, QUIET);
      prev_lo = lo_byte;
      prev_hi = hi_byte;
    end
  endtask

  initial begin : result_stalls
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    dsfa_pkg::result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_reports.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $error("result transfer with no result awaited");
        end
        fail_count++;
      end else begin
        want = awaited_reports.pop_front();
        if (out_ch.frame_ok !== want.frame_ok)
          log_mismatch("frame_ok", want.frame_ok, out_ch.frame_ok);
        if (out_ch.frame_kind !== want.frame_kind)
          log_mismatch("frame_kind", want.frame_kind, out_ch.frame_kind);
        if (out_ch.fine_reading !== want.fine_reading)
          log_mismatch("fine_reading", want.fine_reading, out_ch.fine_reading);
        if (out_ch.coarse_reading !== want.coarse_reading)
          log_mismatch("coarse_reading", want.coarse_reading, out_ch.coarse_reading);
        if (out_ch.new_reading !== want.new_reading)
          log_mismatch("new_reading", want.new_reading, out_ch.new_reading);
        if (out_ch.average_valid !== want.average_valid)
          log_mismatch("average_valid", want.average_valid, out_ch.average_valid);
        if (out_ch.fine_average !== want.fine_average)
          log_mismatch("fine_average", want.fine_average, out_ch.fine_average);
        if (out_ch.coarse_average !== want.coarse_average)
          log_mismatch("coarse_average", want.coarse_average, out_ch.coarse_average);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int base;
    int pick;
    in_ch.valid     = 1'b0;
    in_ch.operation = dsfa_pkg::OP_PUSH;
    in_ch.rx_byte   = 8'h00;
    directed_rows = '{
      '{dsfa_pkg::OP_POLL, 8'h00, 1'b1, QUIET},
      '{dsfa_pkg::OP_READ, 8'h00, 1'b1, QUIET},
      '{OP_UNUSED,         8'hFF, 1'b1, QUIET},
      // tenths frame, PM2.5 at full scale, PM10 zero
      '{dsfa_pkg::OP_PUSH, 8'hAA, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hC0, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hFF, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hFF, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'h00, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'h00, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'h5A, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hA5, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hFD, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hAB, 1'b1, C0_FRAME_MAX},
      // whole-unit frame, PM2.5 at full scale times ten, PM10 zero
      '{dsfa_pkg::OP_PUSH, 8'hAA, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hCF, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'h00, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'h00, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hFF, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hFF, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'h00, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'h00, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hFE, 1'b0, QUIET},
      '{dsfa_pkg::OP_PUSH, 8'hAB, 1'b1, CF_FRAME_MAX},
      '{dsfa_pkg::OP_POLL, 8'h00, 1'b1, FLAG_RAISED},
      '{dsfa_pkg::OP_READ, 8'h00, 1'b0, QUIET},
      '{dsfa_pkg::OP_READ, 8'h00, 1'b1, QUIET}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].op, directed_rows[r].rx, directed_rows[r].typed,
                directed_rows[r].want);
    end

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame(FAULT_NONE);
      end else if (pick < 60) begin
        send_frame(frame_fault_t'($urandom_range(1, 4)));
      end else if (pick < 68) begin
        send_frame_chain($urandom_range(1, 4));
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(dsfa_pkg::OP_PUSH,
                    ($urandom_range(0, 3) == 0) ? dsfa_pkg::FRAME_HEAD : 8'($urandom),
                    1'b0, QUIET);
        end
      end else if (pick < 88) begin
        send_item(dsfa_pkg::OP_POLL, 8'($urandom), 1'b0, QUIET);
      end else if (pick < 96) begin
        send_item(dsfa_pkg::OP_READ, 8'($urandom), 1'b0, QUIET);
      end else begin
        send_item(OP_UNUSED, 8'($urandom), 1'b0, QUIET);
      end
    end

    // Final stretch back to back, no idling from here on.
    idle_on = 1'b0;
    send_item(dsfa_pkg::OP_READ, 8'h00, 1'b0, QUIET);
    send_frame_chain(TAIL_FRAMES);
    send_item(dsfa_pkg::OP_POLL, 8'h00, 1'b0, QUIET);
    send_item(dsfa_pkg::OP_READ, 8'h00, 1'b0, QUIET);
    send_item(dsfa_pkg::OP_READ, 8'h00, 1'b0, QUIET);
    in_ch.valid = 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ dust_sensor_frame_averager_unit.f @@
+incdir+rtl
rtl/dsfa_pkg.sv
rtl/dsfa_channel_if.sv
rtl/dsfa_frame_parser.sv
rtl/dsfa_divider.sv
rtl/dust_sensor_frame_averager_unit.sv
dv/testbench.sv
